// ===== src/kbw_pkg.sv =====
package kbw_pkg;

	localparam int MAX_K_DEF = 63;
	localparam int K_W = 6;
	localparam logic [K_W-1:0] KMER_SIZE_RESET = 6'd31;

	typedef enum logic [2:0] {
		CMD_SHIFT_END   = 3'd0,
		CMD_SHIFT_FRONT = 3'd1,
		CMD_SET         = 3'd2,
		CMD_READ        = 3'd3,
		CMD_CLEAR       = 3'd4
	} cmd_t;

	typedef struct packed {
		logic [2:0]     command;
		logic [7:0]     base_char;
		logic [K_W-1:0] position;
	} item_t;

	typedef struct packed {
		logic [7:0]  base_at_position;
		logic [7:0]  last_base;
		logic [63:0] window_hash;
		logic        bad_input;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic [2:0] code;
	} code_t;

	function automatic code_t char_to_code(input logic [7:0] ch);
		code_t r;
		r.ok = 1'b1;
		case (ch)
			8'h41, 8'h61: r.code = 3'd0;
			8'h43, 8'h63: r.code = 3'd1;
			8'h47, 8'h67: r.code = 3'd2;
			8'h54, 8'h74: r.code = 3'd3;
			8'h42, 8'h62: r.code = 3'd4;
			8'h48, 8'h68: r.code = 3'd5;
			8'h44, 8'h64: r.code = 3'd6;
			8'h4E, 8'h6E: r.code = 3'd7;
			default: begin
				r.ok = 1'b0;
				r.code = 3'd0;
			end
		endcase
		return r;
	endfunction

	function automatic logic [7:0] code_to_ascii(input logic [2:0] code);
		logic [7:0] a;
		case (code)
			3'd0: a = 8'h41;
			3'd1: a = 8'h43;
			3'd2: a = 8'h47;
			3'd3: a = 8'h54;
			3'd4: a = 8'h42;
			3'd5: a = 8'h48;
			3'd6: a = 8'h44;
			3'd7: a = 8'h4E;
			default: a = 8'h4E;
		endcase
		return a;
	endfunction

endpackage

// ===== src/kbw_if.sv =====
interface kbw_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic [7:0] base_char;
	logic [5:0] position;

	modport source (output valid, command, base_char, position, input ready);
	modport sink (input valid, command, base_char, position, output ready);
endinterface

interface kbw_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  base_at_position;
	logic [7:0]  last_base;
	logic [63:0] window_hash;
	logic        bad_input;

	modport source (output valid, base_at_position, last_base, window_hash, bad_input,
		input ready);
	modport sink (input valid, base_at_position, last_base, window_hash, bad_input,
		output ready);
endinterface

// ===== src/kmer_bitplane_window_top.sv =====
// rolling k-mer window held as three bit planes of 3-bit base codes. one item is
// accepted per cycle with no bubbles while rsp.ready is high; it passes the
// input register, plane update into the plane registers and output register to rsp.
// rate is set by the plane update, the only dependency between consecutive items.
// the user must write kmer_size through cfg_we and cfg_wdata only while the block is
// idle (not enforced by the block); kmer_size resets to 31, clamped to 1..MAX_K.
module kmer_bitplane_window_top #(
	parameter int MAX_K = kbw_pkg::MAX_K_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [kbw_pkg::K_W-1:0] cfg_wdata,
	kbw_in_if.sink                  req,
	kbw_out_if.source               rsp
);

	logic [kbw_pkg::K_W-1:0] kmer_size_q;
	kbw_pkg::item_t          item_s1;
	logic                    v_s1;
	logic [MAX_K-1:0]        low_q, mid_q, high_q;
	logic [kbw_pkg::K_W-1:0] k_s2;
	logic [kbw_pkg::K_W-1:0] pos_s2;
	logic                    bad_s2;
	logic                    v_s2;
	kbw_pkg::result_t        res_q;
	logic                    v_out_q;

	logic [MAX_K-1:0]        low_nxt, mid_nxt, high_nxt;
	logic [kbw_pkg::K_W-1:0] upd_k;
	logic                    upd_bad;
	kbw_pkg::result_t        rep;
	logic                    adv_out, adv_s2, acc;

	assign adv_out = v_s2 && (!v_out_q || rsp.ready);
	assign adv_s2 = v_s1 && (!v_s2 || adv_out);
	assign req.ready = !v_s1 || adv_s2;
	assign acc = req.valid && req.ready;

	kbw_update #(.MAX_K(MAX_K)) u_update (
		.kmer_size (kmer_size_q),
		.item      (item_s1),
		.low       (low_q),
		.mid       (mid_q),
		.high      (high_q),
		.low_nxt   (low_nxt),
		.mid_nxt   (mid_nxt),
		.high_nxt  (high_nxt),
		.k         (upd_k),
		.bad       (upd_bad)
	);

	// planes only move when s2 empties, so they always match the item in s2
	kbw_report #(.MAX_K(MAX_K)) u_report (
		.k        (k_s2),
		.position (pos_s2),
		.bad      (bad_s2),
		.low      (low_q),
		.mid      (mid_q),
		.high     (high_q),
		.res      (rep)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_size_q <= kbw_pkg::KMER_SIZE_RESET;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_out_q <= 1'b0;
			low_q <= '0;
			mid_q <= '0;
			high_q <= '0;
		end else begin
			if (cfg_we)
				kmer_size_q <= cfg_wdata;
			if (req.ready)
				v_s1 <= req.valid;
			if (!v_s2 || adv_out)
				v_s2 <= v_s1;
			if (!v_out_q || rsp.ready)
				v_out_q <= v_s2;
			if (adv_s2) begin
				low_q <= low_nxt;
				mid_q <= mid_nxt;
				high_q <= high_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1.command <= req.command;
			item_s1.base_char <= req.base_char;
			item_s1.position <= req.position;
		end
		if (adv_s2) begin
			k_s2 <= upd_k;
			pos_s2 <= item_s1.position;
			bad_s2 <= upd_bad;
		end
		if (adv_out)
			res_q <= rep;
	end

	assign rsp.valid = v_out_q;
	assign rsp.base_at_position = res_q.base_at_position;
	assign rsp.last_base = res_q.last_base;
	assign rsp.window_hash = res_q.window_hash;
	assign rsp.bad_input = res_q.bad_input;

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && item_s1.command == kbw_pkg::CMD_CLEAR
		|=> low_q == '0 && mid_q == '0 && high_q == '0)
		else $error("planes not cleared");

	a_hold_planes: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s2 |=> $stable(low_q) && $stable(mid_q) && $stable(high_q))
		else $error("planes moved without an item");

	a_bad_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && upd_bad |=> $stable(low_q) && $stable(mid_q) && $stable(high_q))
		else $error("rejected item changed planes");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> req.ready)
		else $error("empty input stage not ready");

	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		adv_out |=> v_out_q)
		else $error("result lost at output register");

endmodule

// ===== src/kbw_update.sv =====
module kbw_update #(
	parameter int MAX_K = kbw_pkg::MAX_K_DEF
) (
	input  logic [kbw_pkg::K_W-1:0] kmer_size,
	input  kbw_pkg::item_t          item,
	input  logic [MAX_K-1:0]        low,
	input  logic [MAX_K-1:0]        mid,
	input  logic [MAX_K-1:0]        high,
	output logic [MAX_K-1:0]        low_nxt,
	output logic [MAX_K-1:0]        mid_nxt,
	output logic [MAX_K-1:0]        high_nxt,
	output logic [kbw_pkg::K_W-1:0] k,
	output logic                    bad
);

	localparam logic [kbw_pkg::K_W-1:0] KMAX = kbw_pkg::K_W'(MAX_K);
	localparam logic [MAX_K-1:0] ONE = MAX_K'(1);

	kbw_pkg::code_t          ch;
	logic                    pos_ok;
	logic [MAX_K-1:0]        mask;
	logic [MAX_K-1:0]        top;
	logic [MAX_K-1:0]        sel;
	logic [kbw_pkg::K_W-1:0] d;

	always_comb begin
		if (kmer_size == '0)
			k = kbw_pkg::K_W'(1);
		else if (kmer_size > KMAX)
			k = KMAX;
		else
			k = kmer_size;
	end

	assign ch = kbw_pkg::char_to_code(item.base_char);
	assign pos_ok = item.position < k;
	// plane bit of the addressed base, counted from the 3' end
	assign d = k - item.position - kbw_pkg::K_W'(1);
	assign top = ONE << (k - kbw_pkg::K_W'(1));
	assign sel = ONE << d;

	always_comb begin
		for (int i = 0; i < MAX_K; i++)
			mask[i] = kbw_pkg::K_W'(i) < k;
	end

	always_comb begin
		low_nxt = low;
		mid_nxt = mid;
		high_nxt = high;
		bad = 1'b0;
		case (kbw_pkg::cmd_t'(item.command))
			kbw_pkg::CMD_SHIFT_END: begin
				if (!ch.ok) begin
					bad = 1'b1;
				end else begin
					low_nxt = {low[MAX_K-2:0], ch.code[0]} & mask;
					mid_nxt = {mid[MAX_K-2:0], ch.code[1]} & mask;
					high_nxt = {high[MAX_K-2:0], ch.code[2]} & mask;
				end
			end
			kbw_pkg::CMD_SHIFT_FRONT: begin
				if (!ch.ok) begin
					bad = 1'b1;
				end else begin
					// bits above k are not cleared, they move down into the window
					low_nxt = {1'b0, low[MAX_K-1:1]} | (ch.code[0] ? top : '0);
					mid_nxt = {1'b0, mid[MAX_K-1:1]} | (ch.code[1] ? top : '0);
					high_nxt = {1'b0, high[MAX_K-1:1]} | (ch.code[2] ? top : '0);
				end
			end
			kbw_pkg::CMD_SET: begin
				if (!ch.ok || !pos_ok) begin
					bad = 1'b1;
				end else begin
					low_nxt = (low & ~sel) | (ch.code[0] ? sel : '0);
					mid_nxt = (mid & ~sel) | (ch.code[1] ? sel : '0);
					high_nxt = (high & ~sel) | (ch.code[2] ? sel : '0);
				end
			end
			kbw_pkg::CMD_READ: begin
				bad = !pos_ok;
			end
			kbw_pkg::CMD_CLEAR: begin
				low_nxt = '0;
				mid_nxt = '0;
				high_nxt = '0;
			end
			default: begin
				bad = 1'b1;
			end
		endcase
	end

endmodule

// ===== src/kbw_report.sv =====
module kbw_report #(
	parameter int MAX_K = kbw_pkg::MAX_K_DEF
) (
	input  logic [kbw_pkg::K_W-1:0] k,
	input  logic [kbw_pkg::K_W-1:0] position,
	input  logic                    bad,
	input  logic [MAX_K-1:0]        low,
	input  logic [MAX_K-1:0]        mid,
	input  logic [MAX_K-1:0]        high,
	output kbw_pkg::result_t        res
);

	localparam int IDX_W = $clog2(MAX_K);

	logic                    pos_ok;
	logic [kbw_pkg::K_W-1:0] d;
	logic [IDX_W-1:0]        b;
	logic [63:0]             sum;
	logic [63:0]             mix;

	assign pos_ok = position < k;
	assign d = k - position - kbw_pkg::K_W'(1);
	// only used when the position is in range, then d < MAX_K
	assign b = d[IDX_W-1:0];

	assign sum = 64'(low) + 64'(mid) + 64'(high);
	// xor of the shifted planes equals the shifted xor
	assign mix = 64'(low ^ mid ^ high) << k;

	always_comb begin
		res.base_at_position = pos_ok ?
			kbw_pkg::code_to_ascii({high[b], mid[b], low[b]}) : 8'd0;
		res.last_base = kbw_pkg::code_to_ascii({high[0], mid[0], low[0]});
		res.window_hash = sum | mix;
		res.bad_input = bad;
	end

endmodule
